[hw/rtl/mi_pkg.sv]
package mi_pkg;

  // Default operand width (low bits of each input field that are used)
  localparam int MI_WIDTH   = 32;
  // Fixed width of the operand, modulus and inverse fields
  localparam int MI_FIELD_W = 32;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_INVERSE = 2'd1,
    STAT_MOD_ZERO   = 2'd2
  } mi_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOOP,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } mi_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic       load;        // capture new item, reset coefficients
    logic       div_start;   // clear remainder/quotient product, arm counter
    logic       div_step;    // one restoring division bit
    logic       update;      // Euclid step: rotate remainders and coefficients
    logic       res_write;   // load output payload register
    logic       res_coef;    // result from coefficient, else zero
    mi_status_t res_status;
  } mi_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic a_zero;
    logic a_le1;
    logic m_zero;
    logic m_one;
    logic div_last;
  } mi_sts_t;

endpackage

[hw/rtl/mi_if.sv]
interface mi_in_if;
  import mi_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MI_FIELD_W-1:0] operand;
  logic [MI_FIELD_W-1:0] modulus;

  modport source (output valid, output operand, output modulus, input ready);
  modport sink   (input valid, input operand, input modulus, output ready);
endinterface

interface mi_out_if;
  import mi_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MI_FIELD_W-1:0] inverse;
  logic [1:0]            status;

  modport source (output valid, output inverse, output status, input ready);
  modport sink   (input valid, input inverse, input status, output ready);
endinterface

[hw/rtl/mi_dp.sv]
module mi_dp
  import mi_pkg::*;
#(
  parameter int WIDTH = MI_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [MI_FIELD_W-1:0] operand,
  input  logic [MI_FIELD_W-1:0] modulus,
  input  mi_cmd_t               cmd,
  output mi_sts_t               sts,
  output logic [MI_FIELD_W-1:0] inverse,
  output logic [1:0]            status
);

  localparam int CW    = WIDTH + 2;
  localparam int CNT_W = $clog2(WIDTH);

  logic [WIDTH-1:0] a_r, m_r, mod0_r, rem_r, dvd_r;
  logic [CW-1:0]    cprev_r, ccur_r, prod_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MI_FIELD_W-1:0] inv_r;
  mi_status_t       stat_r;

  logic [MI_FIELD_W+WIDTH-1:0] op_ext, md_ext;
  logic [WIDTH:0]   trial, diff, m_ext;
  logic             ge;
  logic [WIDTH-1:0] rem_nxt;
  logic [CW-1:0]    prod_nxt, res_sum;
  logic [CW+MI_FIELD_W-1:0] res_ext;

  assign op_ext = {{WIDTH{1'b0}}, operand};
  assign md_ext = {{WIDTH{1'b0}}, modulus};

  // restoring division, one quotient bit per cycle; quotient bits feed
  // a shift-and-add product with the current coefficient
  assign trial    = {rem_r, dvd_r[WIDTH-1]};
  assign m_ext    = {1'b0, m_r};
  assign ge       = (trial >= m_ext);
  assign diff     = trial - m_ext;
  assign rem_nxt  = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
  assign prod_nxt = {prod_r[CW-2:0], 1'b0} + (ge ? ccur_r : '0);

  // negative coefficient gets the modulus added once
  assign res_sum = cprev_r + (cprev_r[CW-1] ? {2'b00, mod0_r} : '0);
  assign res_ext = {{MI_FIELD_W{1'b0}}, res_sum};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r     <= op_ext[WIDTH-1:0];
      m_r     <= md_ext[WIDTH-1:0];
      mod0_r  <= md_ext[WIDTH-1:0];
      cprev_r <= CW'(1);
      ccur_r  <= '0;
    end
    if (cmd.div_start) begin
      rem_r  <= '0;
      dvd_r  <= a_r;
      prod_r <= '0;
      cnt_r  <= CNT_W'(WIDTH - 1);
    end
    if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {dvd_r[WIDTH-2:0], 1'b0};
      prod_r <= prod_nxt;
      cnt_r  <= cnt_r - 1'b1;
    end
    if (cmd.update) begin
      a_r     <= m_r;
      m_r     <= rem_r;
      ccur_r  <= cprev_r - prod_r;
      cprev_r <= ccur_r;
    end
    if (cmd.res_write) begin
      inv_r  <= cmd.res_coef ? res_ext[MI_FIELD_W-1:0] : '0;
      stat_r <= cmd.res_status;
    end
  end

  assign sts.a_zero   = (a_r == '0);
  assign sts.a_le1    = (a_r[WIDTH-1:1] == '0);
  assign sts.m_zero   = (m_r == '0);
  assign sts.m_one    = (m_r[WIDTH-1:1] == '0) && m_r[0];
  assign sts.div_last = (cnt_r == '0);

  assign inverse = inv_r;
  assign status  = stat_r;

`ifndef SYNTHESIS
  a_no_div_by_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> m_r != '0)
    else $error("division step with zero divisor");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> rem_r < m_r)
    else $error("remainder not below divisor");

  a_inv_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_write && cmd.res_coef) |-> (res_sum < {2'b00, mod0_r}))
    else $error("inverse out of range");
`endif

endmodule

[hw/rtl/mi_ctrl.sv]
module mi_ctrl
  import mi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output mi_cmd_t cmd,
  input  mi_sts_t sts
);

  mi_state_t  state_r, state_nxt;
  mi_status_t fin_stat_r, fin_stat_nxt;
  logic       fin_coef_r, fin_coef_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fin_stat_r  <= STAT_OK;
      fin_coef_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_stat_r  <= fin_stat_nxt;
      fin_coef_r  <= fin_coef_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    fin_stat_nxt   = fin_stat_r;
    fin_coef_nxt   = fin_coef_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.res_status = fin_stat_r;
    cmd.res_coef   = fin_coef_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        fin_coef_nxt = 1'b0;
        if (sts.m_zero) begin
          fin_stat_nxt = STAT_MOD_ZERO;
          state_nxt    = ST_FINISH;
        end else if (sts.m_one) begin
          fin_stat_nxt = STAT_OK;
          state_nxt    = ST_FINISH;
        end else if (sts.a_zero) begin
          fin_stat_nxt = STAT_NO_INVERSE;
          state_nxt    = ST_FINISH;
        end else begin
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (sts.a_le1) begin
          fin_stat_nxt = STAT_OK;
          fin_coef_nxt = 1'b1;
          state_nxt    = ST_FINISH;
        end else if (sts.m_zero) begin
          // gcd above one
          fin_stat_nxt = STAT_NO_INVERSE;
          fin_coef_nxt = 1'b0;
          state_nxt    = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_LOOP;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_write = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/modular_inverse_unit_core.sv]
// Modular inverse by the extended Euclidean algorithm. Each input item
// (operand, modulus) gives one result item (inverse, status). Only the low
// WIDTH bits of each field are used; the inverse field carries the low 32
// bits of a result in 0 .. modulus-1. Status: ok; no_inverse when operand
// and modulus share a factor or the operand is zero (inverse 0);
// modulus_zero for a zero modulus (inverse 0). A modulus of one gives 0, ok.
// An operand at or above the modulus is reduced by the first step.
// Timing: one item at a time. Each Euclid step is a restoring divider that
// produces one quotient bit per cycle, with the quotient-times-coefficient
// product built by shift-and-add in the same cycles; an update state then
// rotates the remainders and coefficients. Zero modulus, modulus one and
// zero operand end right after the check state, with no division steps.
// The result sits in an output register, so the next item is accepted
// while the previous result still waits to be taken.
module modular_inverse_unit_core
  import mi_pkg::*;
#(
  parameter int WIDTH = MI_WIDTH
) (
  input logic       clk,
  input logic       rst_n,
  mi_in_if.sink     in_if,
  mi_out_if.source  out_if
);

  mi_cmd_t cmd;
  mi_sts_t sts;

  // FSM: sequences check, division steps, update and result write
  mi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // remainders, coefficients (WIDTH+2 bits signed), divider, output payload
  mi_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .operand (in_if.operand),
    .modulus (in_if.modulus),
    .cmd     (cmd),
    .sts     (sts),
    .inverse (out_if.inverse),
    .status  (out_if.status)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("item accepted while busy");

  a_error_zero_inv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.status != STAT_OK)) |-> (out_if.inverse == '0))
    else $error("nonzero inverse with error status");
`endif

endmodule
